// File: hw/rtl/imf_pkg.sv
package imf_pkg;

    localparam int MaxWidth  = 128;
    localparam int MaxHeight = 128;
    localparam int MaxWindow = 49;
    localparam int ColW      = 7;
    localparam int RowW      = 7;
    localparam int AddrW     = ColW + RowW;
    localparam int PixW      = 32;
    localparam int CountW    = 6;
    localparam int QueueDepth = 2;

    localparam logic       OP_STORE = 1'b0;
    localparam logic       OP_QUERY = 1'b1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_KERNEL = 2'd2;

    // One classified command between the front and the back.
    typedef struct packed {
        logic               query;
        logic               pos_error;
        logic [ColW-1:0]    column;
        logic [RowW-1:0]    row;
        logic [PixW-1:0]    pixel;
        logic [7:0]         width;
        logic [7:0]         height;
        logic [2:0]         side;
    } cmd_t;

endpackage

// File: hw/rtl/imf_front.sv
module imf_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,
    output logic                  cmd_valid,
    input  logic                  cmd_ready,
    output imf_pkg::cmd_t         cmd
);

    logic [7:0] width_reg;
    logic [7:0] height_reg;
    logic [2:0] kernel_reg;

    imf_pkg::cmd_t queue_reg [imf_pkg::QueueDepth];
    logic [1:0]    count_reg;
    logic          wptr_reg;
    logic          rptr_reg;

    imf_pkg::cmd_t incoming;
    logic [7:0]    w_eff;
    logic [7:0]    h_eff;
    logic          push;
    logic          pop;

    always_comb
    begin
        w_eff = (width_reg > 8'(imf_pkg::MaxWidth)) ? 8'(imf_pkg::MaxWidth) : width_reg;
        h_eff = (height_reg > 8'(imf_pkg::MaxHeight)) ? 8'(imf_pkg::MaxHeight) : height_reg;
        incoming.query  = s_tdata[0];
        incoming.column = s_tdata[7:1];
        incoming.row    = s_tdata[14:8];
        incoming.pixel  = s_tdata[46:15];
        incoming.width  = w_eff;
        incoming.height = h_eff;
        incoming.side   = (kernel_reg == 3'd5 || kernel_reg == 3'd7) ? kernel_reg : 3'd3;
        incoming.pos_error = ({1'b0, s_tdata[7:1]} >= w_eff) ||
                             ({1'b0, s_tdata[14:8]} >= h_eff);
    end

    assign s_tready  = (count_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = queue_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd64;
            height_reg <= 8'd64;
            kernel_reg <= 3'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                imf_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                imf_pkg::REG_HEIGHT: height_reg <= cfg_data;
                imf_pkg::REG_KERNEL: kernel_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                wptr_reg <= ~wptr_reg;
            if (pop)
                rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wptr_reg] <= incoming;
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> (wptr_reg == rptr_reg))
        else $error("empty queue with unequal pointers");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("push not counted");

endmodule

// File: hw/rtl/imf_back.sv
module imf_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  imf_pkg::cmd_t         cmd,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE, S_GATHER, S_WAIT, S_RANK, S_PICK, S_OUT
    } state_t;

    state_t state_reg;

    logic [imf_pkg::PixW-1:0] mem [imf_pkg::MaxWidth * imf_pkg::MaxHeight];
    logic [imf_pkg::PixW-1:0] rd_data_reg;

    // Window buffer: register file filled in order, two registered read slots.
    logic [imf_pkg::PixW-1:0] win_reg [imf_pkg::MaxWindow];
    imf_pkg::cmd_t             cmd_reg;
    logic [2:0]                dx_reg, dy_reg;
    logic [imf_pkg::CountW-1:0] n_reg;
    logic [imf_pkg::CountW-1:0] i_reg, j_reg;
    logic [imf_pkg::CountW-1:0] less_reg, equal_reg;
    logic [imf_pkg::PixW-1:0]   cand_reg;
    logic [imf_pkg::PixW-1:0]   median_reg;
    logic [imf_pkg::PixW-1:0]   win_j_reg;
    logic                       rd_pend_reg;
    logic                       hit_reg;
    logic                       perr_reg;

    logic signed [8:0] x_s, y_s;
    logic [2:0]        half;
    logic              inb;
    logic [imf_pkg::AddrW-1:0] rd_addr;
    logic [imf_pkg::CountW-1:0] win_idx;
    logic [imf_pkg::CountW-1:0] target;

    always_comb
    begin
        half = cmd_reg.side >> 1;
        x_s  = $signed({2'b0, cmd_reg.column}) + $signed({6'b0, dx_reg}) - $signed({6'b0, half});
        y_s  = $signed({2'b0, cmd_reg.row}) + $signed({6'b0, dy_reg}) - $signed({6'b0, half});
        inb  = !x_s[8] && !y_s[8] && (x_s[7:0] < cmd_reg.width) && (y_s[7:0] < cmd_reg.height);
        rd_addr = {y_s[imf_pkg::RowW-1:0], x_s[imf_pkg::ColW-1:0]};
        // The element compared in the next cycle is fetched into win_j_reg in this one.
        win_idx = (hit_reg && j_reg != n_reg - 6'd1) ? j_reg + 6'd1 : j_reg;
        target = n_reg >> 1;
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = {1'b0, perr_reg, n_reg, median_reg};

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready && !cmd.query)
            mem[{cmd.row, cmd.column}] <= cmd.pixel;
        rd_data_reg <= mem[rd_addr];
        if (rd_pend_reg)
            win_reg[n_reg] <= rd_data_reg;
        if (state_reg == S_RANK && j_reg == 6'd0)
            cand_reg <= win_reg[i_reg];
        win_j_reg <= win_reg[win_idx];
    end

    // Ranking: for each candidate i, count elements below it and equal to it;
    // the candidate sits at sorted index target when less <= target < less+equal.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rd_pend_reg <= 1'b0;
            n_reg       <= '0;
            perr_reg    <= 1'b0;
            median_reg  <= '0;
        end
        else
        begin
            rd_pend_reg <= (state_reg == S_GATHER) && inb;
            if (rd_pend_reg)
                n_reg <= n_reg + 6'd1;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid && cmd.query)
                    begin
                        cmd_reg    <= cmd;
                        dx_reg     <= '0;
                        dy_reg     <= '0;
                        n_reg      <= '0;
                        perr_reg   <= cmd.pos_error;
                        median_reg <= '0;
                        state_reg  <= cmd.pos_error ? S_OUT : S_GATHER;
                    end
                end
                S_GATHER:
                begin
                    if (dx_reg == cmd_reg.side - 3'd1)
                    begin
                        dx_reg <= '0;
                        if (dy_reg == cmd_reg.side - 3'd1)
                            state_reg <= S_WAIT;
                        else
                            dy_reg <= dy_reg + 3'd1;
                    end
                    else
                        dx_reg <= dx_reg + 3'd1;
                end
                S_WAIT:
                begin
                    if (!rd_pend_reg)
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        hit_reg   <= 1'b0;
                        state_reg <= (n_reg == 6'd0) ? S_OUT : S_RANK;
                    end
                end
                S_RANK:
                begin
                    // First cycle of a candidate loads it; then one compare a cycle.
                    if (j_reg == 6'd0 && !hit_reg)
                    begin
                        less_reg  <= '0;
                        equal_reg <= '0;
                        hit_reg   <= 1'b1;
                    end
                    else
                    begin
                        if ($signed(win_j_reg) < $signed(cand_reg))
                            less_reg <= less_reg + 6'd1;
                        else if (win_j_reg == cand_reg)
                            equal_reg <= equal_reg + 6'd1;
                        if (j_reg == n_reg - 6'd1)
                            state_reg <= S_PICK;
                        else
                            j_reg <= j_reg + 6'd1;
                    end
                end
                S_PICK:
                begin
                    if (less_reg <= target && target < less_reg + equal_reg)
                    begin
                        median_reg <= cand_reg;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 6'd1;
                        j_reg     <= '0;
                        hit_reg   <= 1'b0;
                        state_reg <= S_RANK;
                    end
                end
                S_OUT:
                begin
                    if (m_tready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && perr_reg) |-> (n_reg == 6'd0))
        else $error("error result with nonzero count");
    assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= 6'(imf_pkg::MaxWindow))
        else $error("window overflow");

endmodule

// File: hw/rtl/image_median_filter.sv
// Channel | Direction | Contents
// s_*     | in        | tdata: operation, column, row, pixel_value (48 bits)
// m_*     | out       | tdata: median_value, window_count, position_error (40 bits)
// cfg_*   | in        | register write: index 0 width, 1 height, 2 kernel size
// A store leaves the queue once the back end is idle. A query leaves the queue, steps
// through side*side window positions, waits for the last read to land, then ranks
// candidates in turn (load, one compare per gathered pixel, pick) until the median
// is found, and presents the result until taken; an out-of-size query skips to it.
// A two-entry command queue lets new items enter while a result waits.
// Reset clears control and configuration; the pixel store is not cleared.
module image_median_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // operation, column, row, pixel_value, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // median_value, window_count, position_error, pad
);

    imf_pkg::cmd_t cmd;
    logic          cmd_valid;
    logic          cmd_ready;

    imf_front u_front (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .s_tvalid, .s_tready, .s_tdata,
        .cmd_valid, .cmd_ready, .cmd
    );

    imf_back u_back (
        .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
        .m_tvalid, .m_tready, .m_tdata
    );

endmodule

// File: dv/image_median_filter_tb.sv
`timescale 1ns / 1ps

module image_median_filter_tb;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int CycleLimit = 10000000;
    localparam int SettleCycles = 3000;
    localparam int StoreSize = imf_pkg::MaxWidth * imf_pkg::MaxHeight;

    typedef struct packed {
        logic               pos_err;
        logic [5:0]         count;
        logic signed [31:0] median;
    } median_result_t;

    typedef struct {
        logic               op;
        logic [6:0]         column;
        logic [6:0]         row;
        logic signed [31:0] pixel;
        bit                 typed;
        median_result_t     result;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // operation, column, row, pixel_value, pad
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // median_value, window_count, position_error, pad

    image_median_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Local copy of the pixel store and the registers.
    logic signed [31:0] pixel_mirror [StoreSize];
    bit         written_map [StoreSize];
    logic [7:0] width_reg;
    logic [7:0] height_reg;
    logic [2:0] kernel_reg;

    median_result_t pending_medians[$];
    int  fail_count;
    int  sender_idle_pct;
    int  receiver_idle_pct;
    int  hold_left;
    int  queries_sent;
    int  stores_sent;
    int  results_seen;
    int  error_results;
    int  cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CycleLimit)
            begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic median_result_t predict_median(input logic [6:0] column,
                                                      input logic [6:0] row);
        median_result_t res;
        logic signed [31:0] window [imf_pkg::MaxWindow];
        logic signed [31:0] key;
        int w, h, side, half, n, x, y, j;
        w = (width_reg > imf_pkg::MaxWidth) ? imf_pkg::MaxWidth : width_reg;
        h = (height_reg > imf_pkg::MaxHeight) ? imf_pkg::MaxHeight : height_reg;
        res = '0;
        if (column >= w || row >= h)
        begin
            res.pos_err = 1'b1;
            return res;
        end
        side = (kernel_reg == 3'd5 || kernel_reg == 3'd7) ? int'(kernel_reg) : 3;
        half = side / 2;
        n = 0;
        for (int dy = 0; dy < side; dy++)
        begin
            for (int dx = 0; dx < side; dx++)
            begin
                y = int'(row) + dy - half;
                x = int'(column) + dx - half;
                if (y < 0 || x < 0 || y >= h || x >= w || n >= imf_pkg::MaxWindow)
                    continue;
                window[n] = pixel_mirror[y*imf_pkg::MaxWidth + x];
                n++;
            end
        end
        for (int i = 1; i < n; i++)
        begin
            key = window[i];
            j = i;
            while (j > 0 && window[j-1] > key)
            begin
                window[j] = window[j-1];
                j--;
            end
            window[j] = key;
        end
        res.median = (n > 0) ? window[n/2] : '0;
        res.count = n[5:0];
        return res;
    endfunction

    // Finds the first never-written pixel that a query at this position would read.
    function automatic bit find_missing(input logic [6:0] column, input logic [6:0] row,
                                        output int mx, output int my);
        int w, h, side, half, x, y;
        w = (width_reg > imf_pkg::MaxWidth) ? imf_pkg::MaxWidth : width_reg;
        h = (height_reg > imf_pkg::MaxHeight) ? imf_pkg::MaxHeight : height_reg;
        mx = 0;
        my = 0;
        if (column >= w || row >= h)
            return 1'b0;
        side = (kernel_reg == 3'd5 || kernel_reg == 3'd7) ? int'(kernel_reg) : 3;
        half = side / 2;
        for (int dy = 0; dy < side; dy++)
        begin
            for (int dx = 0; dx < side; dx++)
            begin
                y = int'(row) + dy - half;
                x = int'(column) + dx - half;
                if (y >= 0 && x >= 0 && y < h && x < w &&
                    !written_map[y*imf_pkg::MaxWidth + x])
                begin
                    mx = x;
                    my = y;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Offers one item and returns once the transfer has happened.
    task automatic send_item(input logic op, input logic [6:0] column,
                             input logic [6:0] row, input logic signed [31:0] pixel,
                             input bit typed, input median_result_t typed_result);
        median_result_t res;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pixel, row, column, op};
        do
            @(posedge clk);
        while (!s_tready);
        if (op == imf_pkg::OP_STORE)
        begin
            pixel_mirror[int'(row)*imf_pkg::MaxWidth + int'(column)] = pixel;
            written_map[int'(row)*imf_pkg::MaxWidth + int'(column)] = 1'b1;
            stores_sent++;
        end
        else
        begin
            res = predict_median(column, row);
            if (typed && res != typed_result)
            begin
                $display("%0t: predictor disagrees with table: expected %h got %h",
                         $time, typed_result, res);
                fail_count++;
            end
            pending_medians.push_back(typed ? typed_result : res);
            queries_sent++;
        end
    endtask

    // Stores random pixels wherever a query at this position would read an empty entry.
    task automatic fill_window(input logic [6:0] column, input logic [6:0] row);
        int mx, my;
        while (find_missing(column, row, mx, my))
            send_item(imf_pkg::OP_STORE, 7'(mx), 7'(my), $urandom, 1'b0, '0);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            imf_pkg::REG_WIDTH:  width_reg  = value;
            imf_pkg::REG_HEIGHT: height_reg = value;
            imf_pkg::REG_KERNEL: kernel_reg = value[2:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] w, input logic [7:0] h, input logic [2:0] k);
        wait_idle();
        write_reg(imf_pkg::REG_WIDTH, w);
        write_reg(imf_pkg::REG_HEIGHT, h);
        write_reg(imf_pkg::REG_KERNEL, {5'd0, k});
    endtask

    function automatic logic [6:0] pick_coord(input int limit);
        int lim;
        lim = (limit > 128) ? 128 : limit;
        if (lim == 0 || $urandom_range(9) == 0)
            return 7'($urandom_range(127));
        case ($urandom_range(3))
            0: return 7'd0;
            1: return 7'(lim - 1);
            default: return 7'($urandom_range(lim - 1));
        endcase
    endfunction

    function automatic logic signed [31:0] pick_pixel();
        case ($urandom_range(7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0000_0000;
            3: return 32'(signed'($urandom_range(15)) - 8);
            default: return $urandom;
        endcase
    endfunction

    // Sets the idle mix by position in the random stream.
    task automatic set_idle_mix(input int done_items);
        if (done_items < 200)
        begin
            sender_idle_pct = 31;
            receiver_idle_pct = 67;
        end
        else if (done_items < 400)
        begin
            sender_idle_pct = 67;
            receiver_idle_pct = 31;
        end
        else
        begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
        end
    endtask

    // Receiver: checks results and drives tready, with an optional long hold-off.
    initial
    begin
        median_result_t got;
        median_result_t want;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[38:0];
                results_seen++;
                if (got.pos_err)
                    error_results++;
                if (pending_medians.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = pending_medians.pop_front();
                    if (got.median !== want.median)
                    begin
                        $display("%0t: median mismatch, expected %0d actual %0d",
                                 $time, want.median, got.median);
                        fail_count++;
                    end
                    if (got.count !== want.count)
                    begin
                        $display("%0t: count mismatch, expected %0d actual %0d",
                                 $time, want.count, got.count);
                        fail_count++;
                    end
                    if (got.pos_err !== want.pos_err)
                    begin
                        $display("%0t: error flag mismatch, expected %b actual %b",
                                 $time, want.pos_err, got.pos_err);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    initial
    begin
        stim_row_t dir_rows [$];
        stim_row_t r;
        median_result_t bad;
        logic op;
        logic [6:0] col;
        logic [6:0] rw;
        int mx, my;
        int done_items;
        int phase_items;

        fail_count = 0;
        hold_left = 0;
        queries_sent = 0;
        stores_sent = 0;
        results_seen = 0;
        error_results = 0;
        sender_idle_pct = 31;
        receiver_idle_pct = 67;
        width_reg = 8'd64;
        height_reg = 8'd64;
        kernel_reg = 3'd3;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = imf_pkg::REG_WIDTH;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        bad = '0;
        bad.pos_err = 1'b1;
        // Queries just outside the reset size read no pixels, so they are safe on an empty store.
        send_item(imf_pkg::OP_QUERY, 7'd64, 7'd0, 32'sd0, 1'b1, bad);
        send_item(imf_pkg::OP_QUERY, 7'd0, 7'd64, 32'sd5, 1'b1, bad);
        send_item(imf_pkg::OP_QUERY, 7'd127, 7'd127, 32'sh7fff_ffff, 1'b1, bad);

        // Directed table; every query first gets the rest of its window written.
        dir_rows.push_back('{imf_pkg::OP_STORE, 7'd5, 7'd5, 32'sh8000_0000, 1'b0, '0});
        dir_rows.push_back('{imf_pkg::OP_STORE, 7'd6, 7'd5, 32'sh7fff_ffff, 1'b0, '0});
        dir_rows.push_back('{imf_pkg::OP_STORE, 7'd4, 7'd5, 32'sh8000_0000, 1'b0, '0});
        dir_rows.push_back('{imf_pkg::OP_STORE, 7'd5, 7'd4, 32'sh7fff_ffff, 1'b0, '0});
        dir_rows.push_back('{imf_pkg::OP_QUERY, 7'd5, 7'd5, 32'sh1234_5678, 1'b0, '0});
        dir_rows.push_back('{imf_pkg::OP_QUERY, 7'd0, 7'd0, 32'sd0, 1'b0, '0});
        dir_rows.push_back('{imf_pkg::OP_QUERY, 7'd63, 7'd63, 32'sd0, 1'b0, '0});
        dir_rows.push_back('{imf_pkg::OP_QUERY, 7'd63, 7'd0, 32'sd0, 1'b0, '0});
        dir_rows.push_back('{imf_pkg::OP_QUERY, 7'd0, 7'd63, 32'sd0, 1'b0, '0});
        dir_rows.push_back('{imf_pkg::OP_QUERY, 7'd64, 7'd63, 32'sd0, 1'b1, bad});
        dir_rows.push_back('{imf_pkg::OP_QUERY, 7'd63, 7'd64, 32'sd0, 1'b1, bad});
        dir_rows.push_back('{imf_pkg::OP_STORE, 7'd127, 7'd127, 32'sh7fff_ffff, 1'b0, '0});
        dir_rows.push_back('{imf_pkg::OP_STORE, 7'd0, 7'd0, 32'sh8000_0000, 1'b0, '0});
        dir_rows.push_back('{imf_pkg::OP_QUERY, 7'd0, 7'd0, 32'sd0, 1'b0, '0});
        dir_rows.push_back('{imf_pkg::OP_QUERY, 7'd10, 7'd20, 32'sd0, 1'b0, '0});
        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            if (r.op == imf_pkg::OP_QUERY)
                fill_window(r.column, r.row);
            send_item(r.op, r.column, r.row, r.pixel, r.typed, r.result);
        end

        // Unused register index must leave the configuration alone.
        wait_idle();
        write_reg(REG_SPARE, 8'hff);
        fill_window(7'd1, 7'd1);
        send_item(imf_pkg::OP_QUERY, 7'd1, 7'd1, 32'sd0, 1'b0, bad);

        configure(8'd128, 8'd128, 3'd7);
        fill_window(7'd0, 7'd0);
        send_item(imf_pkg::OP_QUERY, 7'd0, 7'd0, 32'sd0, 1'b0, bad);
        fill_window(7'd127, 7'd127);
        send_item(imf_pkg::OP_QUERY, 7'd127, 7'd127, 32'sd0, 1'b0, bad);
        fill_window(7'd64, 7'd64);
        send_item(imf_pkg::OP_QUERY, 7'd64, 7'd64, 32'sd0, 1'b0, bad);
        configure(8'd255, 8'd255, 3'd5);
        fill_window(7'd127, 7'd0);
        send_item(imf_pkg::OP_QUERY, 7'd127, 7'd0, 32'sd0, 1'b0, bad);
        fill_window(7'd2, 7'd126);
        send_item(imf_pkg::OP_QUERY, 7'd2, 7'd126, 32'sd0, 1'b0, bad);
        configure(8'd0, 8'd0, 3'd0);
        send_item(imf_pkg::OP_QUERY, 7'd0, 7'd0, 32'sd0, 1'b1, bad);

        // Random phases: each entry is width, height, kernel size and item count.
        // A query whose window is not fully written turns into a store into that window.
        done_items = 0;
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: begin configure(8'd128, 8'd128, 3'd3); phase_items = 120; end
                1: begin configure(8'd1, 8'd1, 3'd3);     phase_items = 25;  end
                2: begin configure(8'd8, 8'd5, 3'd4);     phase_items = 55;  end
                3: begin configure(8'd200, 8'd17, 3'd5);  phase_items = 50;  end
                4: begin configure(8'd128, 8'd128, 3'd7); phase_items = 20;  end
                5: begin configure(8'd20, 8'd30, 3'd6);   phase_items = 80;  end
                6: begin configure(8'd0, 8'd40, 3'd1);    phase_items = 15;  end
                7: begin configure(8'd128, 8'd1, 3'd3);   phase_items = 50;  end
                8: begin configure(8'd100, 8'd128, 3'd2); phase_items = 105; end
                default: begin configure(8'd64, 8'd64, 3'd3); phase_items = 80; end
            endcase
            for (int i = 0; i < phase_items; i++)
            begin
                set_idle_mix(done_items);
                if (done_items == 480)
                    hold_left = 800;
                op = ($urandom_range(99) < 55) ? imf_pkg::OP_QUERY : imf_pkg::OP_STORE;
                col = pick_coord(width_reg);
                rw = pick_coord(height_reg);
                if (op == imf_pkg::OP_QUERY && find_missing(col, rw, mx, my))
                begin
                    op = imf_pkg::OP_STORE;
                    col = 7'(mx);
                    rw = 7'(my);
                end
                send_item(op, col, rw, pick_pixel(), 1'b0, bad);
                done_items++;
            end
        end

        wait_idle();
        $display("Covered %0d stores and %0d queries; %0d results checked, %0d flagged out of size.",
                 stores_sent, queries_sent, results_seen, error_results);
        $display("Registers swept through zero, one, full and over-range sizes with every kernel code.");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
